// ----- hw/rtl/bsa_pkg.sv -----
package bsa_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;
endpackage

// ----- hw/rtl/bsa_muldiv.sv -----
module bsa_muldiv #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] q
);
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);
  logic [PW-1:0] prod;
  logic [W:0]    rem;
  logic [W-1:0]  dreg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    sh;
  logic          ge;

  assign sh = {rem[W-1:0], prod[PW-1]};
  assign ge = sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      prod <= PW'(a) * PW'(b);
      dreg <= den;
      rem  <= '0;
      q    <= '0;
      cnt  <= CW'(PW);
      busy <= 1'b1;
    end else if (busy) begin
      prod <= prod << 1;
      rem  <= ge ? sh - {1'b0, dreg} : sh;
      q    <= {q[W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- hw/rtl/bounding_sphere_accumulate_core.sv -----
// Running bounding sphere, signed fixed point.
// Input channel: in_valid/in_stall carrying command, in_x/y/z, in_radius.
// Output channel: out_valid/out_stall carrying the sphere after each beat.
// Each input beat gives exactly one output beat; one beat is worked on at a time.
// Steps from acceptance to a valid result:
// clear, unused command or a first add: straight to the output state.
// Add on a nonempty sphere: form, square and sum the offsets of the three axes,
// then COORD_WIDTH+2 square-root steps and a decision step, when the sphere
// is left as is or replaced.
// A center move adds three shared multiply-divide passes, one per axis,
// and one step for the radius clip.
// The square root and the shared multiply-divide unit are iterative.
// The next beat can be taken the cycle after the result is registered.
// in_stall is low only in idle. A stalled output holds its beat; one further
// beat can be taken meanwhile and its result waits until the output drains.
// Reset (rst, synchronous) empties the sphere: center and radius zero.
module bounding_sphere_accumulate_core #(
  parameter int COORD_WIDTH = bsa_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS = bsa_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic [COORD_WIDTH-2:0] in_radius,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH-1:0] center_z,
  output logic [COORD_WIDTH-2:0] sphere_radius,
  output logic                   is_empty,
  output logic                   saturated
);
  import bsa_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int MW = CW + 2;
  localparam int SW = 2 * CW + 3;
  localparam int RW = CW + 2;
  localparam int QC = $clog2(RW + 1);
  localparam logic [CW-2:0] RMAX = '1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DIFF = 9'b000000010, S_SQ = 9'b000000100,
    S_SQRT = 9'b000001000, S_DEC = 9'b000010000, S_MD = 9'b000100000,
    S_MDW = 9'b001000000, S_FIN = 9'b010000000, S_OUT = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic signed [CW-1:0] px [3];
  logic signed [CW-1:0] hc [3];
  logic [CW-2:0] rin, hr;
  logic empty, sat;
  logic signed [CW:0] off [3];
  logic [1:0] ax;
  logic [SW-1:0] ssum;
  logic [RW-1:0] root;
  logic [QC-1:0] qcnt;
  logic [MW-1:0] num, den;
  logic [CW:0] newr;
  logic md_start, md_done;
  logic [MW-1:0] md_q, md_a;
  logic [CW:0] mag;
  logic [SW-1:0] trial_sq;
  logic [RW-1:0] trial;

  assign mag = off[ax][CW] ? -off[ax] : off[ax];
  assign md_a = MW'(mag);
  assign trial = root | (RW'(1) << qcnt);
  assign trial_sq = SW'(trial) * SW'(trial);

  bsa_muldiv #(.W(MW)) u_md (
    .clk(clk), .rst(rst), .start(md_start), .a(md_a), .b(num), .den(den),
    .done(md_done), .q(md_q)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    md_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      empty <= 1'b1;
      hr <= '0;
      for (int i = 0; i < 3; i++) hc[i] <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= command; px[0] <= in_x; px[1] <= in_y; px[2] <= in_z;
          rin <= in_radius; sat <= 1'b0;
          if (command == CMD_CLEAR) begin
            empty <= 1'b1; hr <= '0;
            for (int i = 0; i < 3; i++) hc[i] <= '0;
            state <= S_OUT;
          end else if (command == CMD_POINT || command == CMD_SPHERE) begin
            if (empty) begin
              hc[0] <= in_x; hc[1] <= in_y; hc[2] <= in_z;
              hr <= (command == CMD_SPHERE) ? in_radius : '0;
              empty <= 1'b0;
              state <= S_OUT;
            end else state <= S_DIFF;
          end else state <= S_OUT;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) off[i] <= {px[i][CW-1], px[i]} - {hc[i][CW-1], hc[i]};
          ax <= 2'd0; ssum <= '0; state <= S_SQ;
        end
        S_SQ: begin
          ssum <= ssum + SW'(mag) * SW'(mag);
          if (ax == 2'd2) begin
            root <= '0; qcnt <= QC'(RW - 1); state <= S_SQRT;
          end else ax <= ax + 2'd1;
        end
        S_SQRT: begin
          if (trial_sq <= ssum) root <= trial;
          if (qcnt == '0) state <= S_DEC;
          else qcnt <= qcnt - 1'b1;
        end
        S_DEC: begin
          ax <= 2'd0;
          state <= S_OUT;
          if (cmd == CMD_POINT) begin
            if (MW'(root) > MW'(hr)) begin
              num <= (MW'(root) - MW'(hr)) >> 1;
              den <= MW'(root);
              newr <= (CW+1)'(hr) + (CW+1)'((MW'(root) - MW'(hr)) >> 1);
              state <= S_MD;
            end
          end else if ((MW'(root) + MW'(rin) < MW'(hr)) ||
                       (root == '0 && rin == hr)) begin
          end else if (MW'(root) + MW'(hr) < MW'(rin)) begin
            for (int i = 0; i < 3; i++) hc[i] <= px[i];
            hr <= rin;
          end else begin
            num <= MW'(root) + MW'(rin) - MW'(hr);
            den <= MW'(root) << 1;
            newr <= (CW+1)'((MW'(root) + MW'(hr) + MW'(rin)) >> 1);
            state <= S_MD;
          end
        end
        S_MD: begin md_start <= 1'b1; state <= S_MDW; end
        S_MDW: if (md_done) begin
          hc[ax] <= off[ax][CW] ? hc[ax] - CW'(md_q) : hc[ax] + CW'(md_q);
          if (ax == 2'd2) state <= S_FIN;
          else begin ax <= ax + 2'd1; state <= S_MD; end
        end
        S_FIN: begin
          if (newr > (CW+1)'(RMAX)) begin hr <= RMAX; sat <= 1'b1; end
          else hr <= newr[CW-2:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            center_x <= hc[0]; center_y <= hc[1]; center_z <= hc[2];
            sphere_radius <= hr; is_empty <= empty; saturated <= sat;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_OUT)) out_valid <= 1'b0;
      if (state == S_OUT && out_valid && !out_stall) out_valid <= 1'b0;
    end
  end
endmodule
